// File: rtl/ufse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufse_pkg - shared types and constants of the spanning edge filter
// Transaction payloads, the command codes and the sequencer status bundle.
// ----------------------------------------------------------------------------
package ufse_pkg;

    // Fixed field widths
    localparam int IDX_W       = 11;
    localparam int NODE_IN_W   = 10;
    localparam int NODE_IN_MAX = 1023;

    // Command codes
    localparam logic OP_EDGE  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Input transaction
    typedef struct packed {
        logic                 op;
        logic [IDX_W-1:0]     edge_index;
        logic [NODE_IN_W-1:0] node_a;
        logic [NODE_IN_W-1:0] node_b;
    } t_in_item;

    // Output transaction
    typedef struct packed {
        logic [IDX_W-1:0] edge_index_out;
        logic             kept;
    } t_out_item;

    // Sequencer status towards the top level
    typedef struct packed {
        logic ready;
        logic res_valid;
    } t_walk_stat;

endpackage

// File: rtl/union_find_spanning_edge_filter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// union_find_spanning_edge_filter_unit - Kruskal style edge filter
// Takes edges one at a time, keeps those that join two trees of the parent
// forest and discards those that would close a cycle; clear resets the forest.
// ----------------------------------------------------------------------------
// One transaction in, one out. An edge is accepted, then the node numbers are
// folded (quotient, then remainder, when NODE_COUNT is below 1024; no folding
// otherwise), then the first forest read is issued, then one forest word is
// read per hop on the walk of each endpoint, and then the result is handed
// over. The forest RAM has a single read port, one hop per cycle. A clear
// sweeps the whole forest RAM one node per cycle. After reset the same sweep
// runs before the first edge is accepted. The result sits in an output
// register, so the next item is taken while an earlier result still waits.
// ----------------------------------------------------------------------------
module union_find_spanning_edge_filter_unit #(
    parameter int NODE_COUNT = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ufse_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ufse_pkg::t_out_item o_out_data
);

    ufse_pkg::t_walk_stat walk_stat;
    ufse_pkg::t_out_item  walk_res;
    logic                 in_accept;
    logic                 out_free;
    logic                 r_out_valid;
    ufse_pkg::t_out_item  r_out_data;

    // Input handshake
    assign o_in_stall = !walk_stat.ready;
    assign in_accept  = i_in_valid && walk_stat.ready;

    // Output register can take a new result
    assign out_free = !r_out_valid || !i_out_stall;

    ufse_walk #(
        .NODE_COUNT (NODE_COUNT)
    ) u_walk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_accept),
        .i_cmd      (i_in_data),
        .i_res_take (out_free),
        .o_stat     (walk_stat),
        .o_res      (walk_res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= walk_stat.res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && walk_stat.res_valid) begin
            r_out_data <= walk_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // A new output transaction only follows a finished walk
    a_out_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(walk_stat.res_valid))
        else $error("output valid without a finished walk");

endmodule

// File: rtl/ufse_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufse_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ufse_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/ufse_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufse_mod - node number folding unit
// Reduces both endpoint numbers modulo NODE_COUNT by reciprocal
// multiplication: first the quotient, then the remainder, both operands in
// parallel. No folding is done when NODE_COUNT covers the input range.
// ----------------------------------------------------------------------------
module ufse_mod #(
    parameter int NODE_COUNT = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [ufse_pkg::NODE_IN_W-1:0]      i_a,
    input  logic [ufse_pkg::NODE_IN_W-1:0]      i_b,
    output logic                                o_idle,
    output logic [$clog2(NODE_COUNT)-1:0]       o_a,
    output logic [$clog2(NODE_COUNT)-1:0]       o_b
);

    localparam int NODE_W    = $clog2(NODE_COUNT);
    localparam int IN_W      = ufse_pkg::NODE_IN_W;
    localparam int CW        = (NODE_W > IN_W) ? NODE_W : IN_W;
    localparam bit FOLD      = (NODE_COUNT <= ufse_pkg::NODE_IN_MAX);
    // ceil(2^SH / N) gives an exact quotient for every input below 2^IN_W
    localparam int SH        = IN_W + NODE_W;
    localparam int RECIP_INT = ((1 << SH) + NODE_COUNT - 1) / NODE_COUNT;
    localparam int MW        = IN_W + 2;
    localparam int PW        = IN_W + MW;
    localparam logic [MW-1:0]   RECIP = MW'(RECIP_INT);
    localparam logic [IN_W-1:0] BASE  = IN_W'(FOLD ? NODE_COUNT : 0);

    logic            r_busy;
    logic            r_phase;
    logic [IN_W-1:0] r_a;
    logic [IN_W-1:0] r_b;
    logic [IN_W-1:0] r_qa;
    logic [IN_W-1:0] r_qb;
    logic [PW-1:0]   prod_a;
    logic [PW-1:0]   prod_b;
    logic [IN_W-1:0] quo_a;
    logic [IN_W-1:0] quo_b;
    logic [IN_W-1:0] back_a;
    logic [IN_W-1:0] back_b;
    logic [CW-1:0]   ext_a;
    logic [CW-1:0]   ext_b;

    // Quotient by reciprocal, then the multiple of the node count to remove
    assign prod_a = PW'(r_a) * PW'(RECIP);
    assign prod_b = PW'(r_b) * PW'(RECIP);
    assign quo_a  = IN_W'(prod_a >> SH);
    assign quo_b  = IN_W'(prod_b >> SH);
    assign back_a = r_qa * BASE;
    assign back_b = r_qb * BASE;

    // Control: quotient step, then remainder step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
        end else if (i_start) begin
            r_busy  <= FOLD;
            r_phase <= 1'b0;
        end else if (r_busy) begin
            r_busy  <= !r_phase;
            r_phase <= !r_phase;
        end
    end

    // Operands and quotients
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end else if (r_busy) begin
            if (!r_phase) begin
                r_qa <= quo_a;
                r_qb <= quo_b;
            end else begin
                r_a <= r_a - back_a;
                r_b <= r_b - back_b;
            end
        end
    end

    // Fit the folded value to the forest index width
    assign ext_a  = CW'(r_a);
    assign ext_b  = CW'(r_b);
    assign o_a    = ext_a[NODE_W-1:0];
    assign o_b    = ext_b[NODE_W-1:0];
    assign o_idle = !r_busy;

endmodule

// File: rtl/ufse_walk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufse_walk - forest sequencer
// Holds the parent forest in one RAM word per node ({has_parent, parent}),
// walks both endpoints to their roots one read per hop, links the roots and
// runs the clearing sweep after reset and on a clear command.
// ----------------------------------------------------------------------------
module ufse_walk #(
    parameter int NODE_COUNT = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  ufse_pkg::t_in_item    i_cmd,
    input  logic                  i_res_take,
    output ufse_pkg::t_walk_stat  o_stat,
    output ufse_pkg::t_out_item   o_res
);

    localparam int NODE_W = $clog2(NODE_COUNT);
    localparam int WORD_W = NODE_W + 1;
    localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODE_COUNT - 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SWEEP = 6'b000010,
        S_RED   = 6'b000100,
        S_CHK_A = 6'b001000,
        S_CHK_B = 6'b010000,
        S_POST  = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    logic [NODE_W-1:0]   r_sweep, n_sweep;
    logic                r_post, n_post;
    logic [NODE_W-1:0]   r_cur, n_cur;
    logic [NODE_W-1:0]   r_nb, n_nb;
    logic [NODE_W-1:0]   r_ra, n_ra;
    logic [ufse_pkg::IDX_W-1:0] r_idx, n_idx;
    ufse_pkg::t_out_item r_res, n_res;

    logic                mod_start;
    logic                mod_idle;
    logic [NODE_W-1:0]   mod_a;
    logic [NODE_W-1:0]   mod_b;

    logic                ram_we;
    logic [NODE_W-1:0]   ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [NODE_W-1:0]   ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;
    logic                rd_has;
    logic [NODE_W-1:0]   rd_par;

    // Node number folding
    ufse_mod #(
        .NODE_COUNT (NODE_COUNT)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_a     (i_cmd.node_a),
        .i_b     (i_cmd.node_b),
        .o_idle  (mod_idle),
        .o_a     (mod_a),
        .o_b     (mod_b)
    );

    // Forest store
    ufse_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NODE_COUNT)
    ) u_forest (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_has = ram_rdata[NODE_W];
    assign rd_par = ram_rdata[NODE_W-1:0];

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_sweep   = r_sweep;
        n_post    = r_post;
        n_cur     = r_cur;
        n_nb      = r_nb;
        n_ra      = r_ra;
        n_idx     = r_idx;
        n_res     = r_res;
        mod_start = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_sweep;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = r_cur;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_idx = i_cmd.edge_index;
                    if (i_cmd.op == ufse_pkg::OP_CLEAR) begin
                        n_sweep = '0;
                        n_post  = 1'b1;
                        n_state = S_SWEEP;
                    end else begin
                        mod_start = 1'b1;
                        n_state   = S_RED;
                    end
                end
            end
            S_SWEEP: begin
                // one entry per cycle back to root
                ram_we    = 1'b1;
                ram_waddr = r_sweep;
                ram_wdata = '0;
                if (r_sweep == LAST_NODE) begin
                    n_res   = '0;
                    n_state = r_post ? S_POST : S_IDLE;
                end else begin
                    n_sweep = r_sweep + NODE_W'(1);
                end
            end
            S_RED: begin
                if (mod_idle) begin
                    ram_re    = 1'b1;
                    ram_raddr = mod_a;
                    n_cur     = mod_a;
                    n_nb      = mod_b;
                    n_state   = S_CHK_A;
                end
            end
            S_CHK_A: begin
                ram_re = 1'b1;
                if (rd_has) begin
                    ram_raddr = rd_par;
                    n_cur     = rd_par;
                end else begin
                    // root of node_a found, start on node_b
                    n_ra      = r_cur;
                    ram_raddr = r_nb;
                    n_cur     = r_nb;
                    n_state   = S_CHK_B;
                end
            end
            S_CHK_B: begin
                if (rd_has) begin
                    ram_re    = 1'b1;
                    ram_raddr = rd_par;
                    n_cur     = rd_par;
                end else begin
                    n_res.edge_index_out = r_idx;
                    if (r_cur == r_ra) begin
                        n_res.kept = 1'b0;
                    end else begin
                        // hang root b under root a
                        ram_we     = 1'b1;
                        ram_waddr  = r_cur;
                        ram_wdata  = {1'b1, r_ra};
                        n_res.kept = 1'b1;
                    end
                    n_state = S_POST;
                end
            end
            S_POST: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_sweep <= '0;
            r_post  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sweep <= n_sweep;
            r_post  <= n_post;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_nb  <= n_nb;
        r_ra  <= n_ra;
        r_idx <= n_idx;
        r_res <= n_res;
    end

    assign o_stat.ready     = (r_state == S_IDLE);
    assign o_stat.res_valid = (r_state == S_POST);
    assign o_res            = r_res;

    // Read and write never share a cycle
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("forest read and write in the same cycle");

    // A link write always sets has_parent and never points a node at itself
    a_link_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && r_state == S_CHK_B) |->
            (ram_wdata[NODE_W] && ram_wdata[NODE_W-1:0] != ram_waddr))
        else $error("bad parent link written");

    // A started command leaves the idle state at once
    a_start_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> !o_stat.ready)
        else $error("sequencer stayed idle after a start");

endmodule
